### design/tsw_pkg.sv
package tsw_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] ADDR_DECODE = 4'd9;
	localparam logic [3:0] ADDR_D6     = 4'd6;
	localparam logic [3:0] ADDR_D7     = 4'd7;
	localparam logic [3:0] ADDR_D8     = 4'd8;

	localparam logic [7:0] DECODE_ALL   = 8'hff;
	localparam logic [7:0] DECODE_MINUS = 8'hdf;
	localparam logic [7:0] CODE_MINUS1  = 8'h31;
	localparam logic [7:0] CODE_DASH    = 8'h0a;
	localparam logic [7:0] CODE_BLANK   = 8'h0f;

	localparam logic [11:0] TENTHS_MAX = 12'hfff;

	typedef struct packed {
		logic [7:0] reading_low;
		logic [7:0] reading_high;
	} reading_t;

	typedef struct packed {
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic       last_write;
	} write_t;

	typedef struct packed {
		logic       neg;
		logic [5:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} cmd_t;

	typedef enum logic [1:0] {
		SLOT_DECODE = 2'd0,
		SLOT_D6     = 2'd1,
		SLOT_D7     = 2'd2,
		SLOT_D8     = 2'd3
	} slot_t;

	function automatic write_t write_for(input cmd_t c, input slot_t slot);
		write_t w;
		logic   h_zero;
		logic   h_one;
		logic   wide_neg;
		h_zero   = (c.hundreds == 6'd0);
		h_one    = (c.hundreds == 6'd1);
		wide_neg = c.neg && !h_zero && !h_one;
		w.last_write = 1'b0;
		case (slot)
			SLOT_DECODE: begin
				w.reg_address = ADDR_DECODE;
				w.reg_data    = (c.neg && h_one) ? DECODE_MINUS : DECODE_ALL;
			end
			SLOT_D6: begin
				w.reg_address = ADDR_D6;
				if (c.neg)
					w.reg_data = h_one ? CODE_MINUS1 : CODE_DASH;
				else
					w.reg_data = h_zero ? CODE_BLANK : {2'b00, c.hundreds};
			end
			SLOT_D7: begin
				w.reg_address = ADDR_D7;
				w.reg_data    = wide_neg ? {2'b00, c.hundreds} : {4'b1000, c.tens};
			end
			SLOT_D8: begin
				w.reg_address = ADDR_D8;
				w.reg_data    = wide_neg ? {4'b0000, c.tens} : {4'b0000, c.ones};
				w.last_write  = 1'b1;
			end
			default: begin
				w.reg_address = ADDR_DECODE;
				w.reg_data    = DECODE_ALL;
			end
		endcase
		return w;
	endfunction

endpackage

### design/tsw_front.sv
module tsw_front import tsw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  reading_t in_data,
	output logic     push_valid,
	input  logic     push_ready,
	output cmd_t     push_cmd
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [11:0] tenths_s1, tenths_s2;
	logic        neg_s1, neg_s2, neg_s3;
	logic [5:0]  h_s2, h_s3;
	logic [6:0]  rem_s3;
	logic [11:0] last_q;

	logic        adv1, adv2, adv3;
	logic        changed;
	logic        in_neg;
	logic [15:0] word;
	logic [15:0] mag;
	logic [18:0] mag_x5;
	logic [15:0] tenths_full;
	logic [11:0] tenths_in;
	logic [24:0] h_prod;
	logic [12:0] h_x100;
	logic [12:0] rem_full;
	logic [14:0] t_prod;
	logic [3:0]  t_val;
	logic [7:0]  t_x10;
	logic [3:0]  o_val;

	// sign, magnitude and tenths
	always_comb begin
		word        = {in_data.reading_high, in_data.reading_low};
		in_neg      = |in_data.reading_high[7:3];
		mag         = in_neg ? (~word + 16'd1) : word;
		mag_x5      = {1'b0, mag, 2'b00} + {3'b000, mag};
		tenths_full = mag_x5[18:3];
		tenths_in   = (|tenths_full[15:12]) ? TENTHS_MAX : tenths_full[11:0];
	end

	assign adv3     = vld_s3 && push_ready;
	assign adv2     = vld_s2 && (!vld_s3 || adv3);
	assign adv1     = vld_s1 && (!vld_s2 || adv2);
	assign in_ready = !vld_s1 || adv1;
	assign changed  = (tenths_s1 != last_q);

	// digit split by reciprocal multiplication
	assign h_prod   = {13'd0, tenths_s1} * 25'd5243;
	assign h_x100   = {7'd0, h_s2} * 13'd100;
	assign rem_full = {1'b0, tenths_s2} - h_x100;
	assign t_prod   = {8'd0, rem_s3} * 15'd205;
	assign t_val    = t_prod[14:11];
	assign t_x10    = {4'd0, t_val} * 8'd10;
	assign o_val    = 4'(({1'b0, rem_s3}) - t_x10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			last_q <= '0;
		end else begin
			if (in_valid && in_ready)
				vld_s1 <= 1'b1;
			else if (adv1)
				vld_s1 <= 1'b0;
			if (adv1) begin
				vld_s2 <= changed;
				if (changed)
					last_q <= tenths_s1;
			end else if (adv2) begin
				vld_s2 <= 1'b0;
			end
			if (adv2)
				vld_s3 <= 1'b1;
			else if (adv3)
				vld_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tenths_s1 <= tenths_in;
			neg_s1    <= in_neg;
		end
		if (adv1) begin
			tenths_s2 <= tenths_s1;
			neg_s2    <= neg_s1;
			h_s2      <= h_prod[24:19];
		end
		if (adv2) begin
			rem_s3 <= rem_full[6:0];
			h_s3   <= h_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign push_valid        = vld_s3;
	assign push_cmd.neg      = neg_s3;
	assign push_cmd.hundreds = h_s3;
	assign push_cmd.tens     = t_val;
	assign push_cmd.ones     = o_val;

endmodule

### design/tsw_fifo.sv
module tsw_fifo import tsw_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  cmd_t                     push_cmd,
	output logic                     full,
	input  logic                     pop,
	output logic                     not_empty,
	output cmd_t                     head,
	output logic [$clog2(Depth+1)-1:0] count
);

	localparam int PtrW = $clog2(Depth);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [$clog2(Depth+1)-1:0] CountMax = ($clog2(Depth+1))'(Depth);

	cmd_t                         mem_q [Depth];
	logic [PtrW-1:0]              wr_ptr_q, rd_ptr_q;
	logic [$clog2(Depth+1)-1:0]   count_q;

	assign count     = count_q;
	assign full      = (count_q == CountMax);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### design/tsw_back.sv
module tsw_back import tsw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	input  cmd_t   cmd,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output write_t out_data
);

	cmd_t   cmd_q;
	logic   busy_q;
	slot_t  slot_q;
	logic   out_valid_q;
	write_t out_q;
	logic   load;
	logic   finishing;

	assign load      = !out_valid_q || out_ready;
	assign finishing = busy_q && load && (slot_q == SLOT_D8);
	assign pop       = cmd_valid && (!busy_q || finishing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= SLOT_DECODE;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q && load)
				out_valid_q <= 1'b1;
			else if (load)
				out_valid_q <= 1'b0;
			if (pop) begin
				busy_q <= 1'b1;
				slot_q <= SLOT_DECODE;
			end else if (busy_q && load) begin
				slot_q <= slot_t'(slot_q + 2'd1);
				if (slot_q == SLOT_D8)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd;
		if (busy_q && load)
			out_q <= write_for(cmd_q, slot_q);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### design/temperature_to_seven_segment_writer_top.sv
// temperature reading to display-driver register writes
// input channel: in_valid / in_ready / in_data carries one raw reading (low and high byte,
// sixteenths of a degree); output channel: out_valid / out_ready / out_data carries one
// register write (address, data byte, last_write flag)
// the front pipeline (three stages) forms the tenths value, drops readings equal to the
// last shown value and splits the rest into digits; a two-entry queue feeds the back end,
// which sends four writes per changed reading from a registered output
// throughput: one reading per cycle is taken while the front pipeline can move; each
// changed reading occupies the back end for four output transactions, sent at one
// output write per cycle while out_ready stays high
// reset clears the last shown value to zero, so a first reading of zero tenths sends nothing
// when the receiver stalls, the output holds its write, the queue fills and the front
// pipeline backs up until in_ready drops; nothing is lost or repeated
module temperature_to_seven_segment_writer_top import tsw_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  reading_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output write_t   out_data
);

	logic                            push_valid;
	logic                            push;
	cmd_t                            push_cmd;
	logic                            q_full;
	logic                            q_not_empty;
	logic                            pop;
	cmd_t                            q_head;
	logic [$clog2(QueueDepth+1)-1:0] q_count;

	assign push = push_valid && !q_full;

	tsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (!q_full),
		.push_cmd   (push_cmd)
	);

	tsw_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head),
		.count     (q_count)
	);

	tsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("pop from empty queue");

	a_last_on_d8: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_write == (out_data.reg_address == ADDR_D8)))
		else $error("last_write flag out of step with address");

	a_decode_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_write
		|=> !out_valid || out_data.reg_address == ADDR_DECODE)
		else $error("run does not start with decode mode write");

endmodule

### dv/tsw_checker.sv
`timescale 1ns / 100ps

module tsw_checker import tsw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  reading_t in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  write_t   out_data,
	output int       failures,
	output int       pending,
	output int       readings,
	output int       changed,
	output int       writes_seen
);

	localparam logic [7:0] DOT = 8'h80;

	logic [11:0] shown_tenths;
	write_t      due_writes[$];
	int          fail_tally;
	int          reading_tally;
	int          changed_tally;
	int          write_tally;

	function automatic write_t make_write(input logic [3:0] addr, input logic [7:0] data,
			input logic last);
		write_t w;
		w.reg_address = addr;
		w.reg_data    = data;
		w.last_write  = last;
		return w;
	endfunction

	function automatic void predict_writes(input reading_t r);
		logic [15:0] raw;
		logic [15:0] mag;
		logic        minus;
		int unsigned tenths;
		logic [7:0]  hun;
		logic [7:0]  ten;
		logic [7:0]  one;
		raw    = {r.reading_high, r.reading_low};
		minus  = (r.reading_high >= 8'd8);
		mag    = minus ? (~raw + 16'd1) : raw;
		tenths = (32'(mag) * 32'd5) >> 3;
		if (tenths > 32'(TENTHS_MAX))
			tenths = 32'(TENTHS_MAX);
		if (12'(tenths) == shown_tenths)
			return;
		shown_tenths = 12'(tenths);
		changed_tally++;
		hun = 8'(tenths / 100);
		ten = 8'((tenths / 10) % 10);
		one = 8'(tenths % 10);
		if (minus && hun >= 8'd2) begin
			due_writes.push_back(make_write(ADDR_DECODE, DECODE_ALL, 1'b0));
			due_writes.push_back(make_write(ADDR_D6, CODE_DASH, 1'b0));
			due_writes.push_back(make_write(ADDR_D7, hun, 1'b0));
			due_writes.push_back(make_write(ADDR_D8, ten, 1'b1));
		end else if (minus && hun == 8'd1) begin
			due_writes.push_back(make_write(ADDR_DECODE, DECODE_MINUS, 1'b0));
			due_writes.push_back(make_write(ADDR_D6, CODE_MINUS1, 1'b0));
			due_writes.push_back(make_write(ADDR_D7, ten | DOT, 1'b0));
			due_writes.push_back(make_write(ADDR_D8, one, 1'b1));
		end else begin
			due_writes.push_back(make_write(ADDR_DECODE, DECODE_ALL, 1'b0));
			if (minus)
				due_writes.push_back(make_write(ADDR_D6, CODE_DASH, 1'b0));
			else
				due_writes.push_back(make_write(ADDR_D6,
					(hun == 8'd0) ? CODE_BLANK : hun, 1'b0));
			due_writes.push_back(make_write(ADDR_D7, ten | DOT, 1'b0));
			due_writes.push_back(make_write(ADDR_D8, one, 1'b1));
		end
	endfunction

	always @(posedge clk) begin
		write_t oldest;
		if (!arst_n) begin
			shown_tenths = '0;
			due_writes.delete();
			fail_tally    = 0;
			reading_tally = 0;
			changed_tally = 0;
			write_tally   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_writes.size() == 0) begin
					$error("unexpected write transaction: reg_address %0d reg_data 0x%02h",
						out_data.reg_address, out_data.reg_data);
					fail_tally++;
				end else begin
					oldest = due_writes.pop_front();
					write_tally++;
					if (out_data.reg_address !== oldest.reg_address) begin
						$error("reg_address expected %0d actual %0d",
							oldest.reg_address, out_data.reg_address);
						fail_tally++;
					end
					if (out_data.reg_data !== oldest.reg_data) begin
						$error("reg_data expected 0x%02h actual 0x%02h",
							oldest.reg_data, out_data.reg_data);
						fail_tally++;
					end
					if (out_data.last_write !== oldest.last_write) begin
						$error("last_write expected %0b actual %0b",
							oldest.last_write, out_data.last_write);
						fail_tally++;
					end
				end
			end
			if (in_valid && in_ready) begin
				reading_tally++;
				predict_writes(in_data);
			end
		end
		pending     <= due_writes.size();
		failures    <= fail_tally;
		readings    <= reading_tally;
		changed     <= changed_tally;
		writes_seen <= write_tally;
	end

endmodule

### dv/tb_temperature_to_seven_segment_writer_top.sv
`timescale 1ns / 100ps

module tb_temperature_to_seven_segment_writer_top;
	import tsw_pkg::*;

	localparam int RANDOM_READINGS = 207;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	reading_t in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	write_t   out_data;

	int failures;
	int pending;
	int readings;
	int changed;
	int writes_seen;

	int send_idle = 30;
	int recv_idle = 64;

	temperature_to_seven_segment_writer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	tsw_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.failures    (failures),
		.pending     (pending),
		.readings    (readings),
		.changed     (changed),
		.writes_seen (writes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_reading(input logic [15:0] word);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid             <= 1'b1;
		in_data.reading_high <= word[15:8];
		in_data.reading_low  <= word[7:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] last_word;
		logic [15:0] word;
		int          walk;
		int          pick;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset start, each sign and digit layout, repeats and saturation
		send_reading(16'h0000);
		send_reading(16'h0010);
		send_reading(16'h0010);
		send_reading(16'h0190);
		send_reading(16'hfff8);
		send_reading(16'hff38);
		send_reading(16'h00c8);
		send_reading(16'hfc90);
		send_reading(16'h0370);
		send_reading(16'h07d0);
		send_reading(16'h07ff);
		send_reading(16'h7fff);
		send_reading(16'h0800);
		send_reading(16'h7fff);
		send_reading(16'h0000);
		send_reading(16'h8000);
		send_reading(16'hffff);
		send_reading(16'h0001);
		send_reading(16'h0002);
		send_reading(16'hff00);
		send_reading(16'h0100);
		send_reading(16'h00ff);
		send_reading(16'h0000);
		last_word = 16'h0000;
		walk      = 400;

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: begin
					send_idle = 30;
					recv_idle = 64;
				end
				1: begin
					send_idle = 64;
					recv_idle = 30;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_READINGS / 3 + 1; n++) begin
				pick = $urandom_range(9);
				if (pick <= 4) begin
					walk = walk + int'($urandom_range(40)) - 20;
					if (walk < -880)
						walk = -880;
					if (walk > 2000)
						walk = 2000;
					word = 16'(walk);
				end else if (pick <= 6) begin
					word = 16'($urandom);
				end else if (pick == 7) begin
					word = last_word;
				end else if (pick == 8) begin
					word = ~last_word + 16'd1;
				end else begin
					word = {8'($urandom_range(127, 8)), 8'($urandom)};
				end
				send_reading(word);
				last_word = word;
			end
		end

		drain();
		$display("covered %0d readings, %0d changed the display, %0d register writes compared",
			readings, changed, writes_seen);
		$display("idle mixes: sender 30 / receiver 64, sender 64 / receiver 30, no idling");
		if (failures == 0 && pending == 0)
			$display("temperature_to_seven_segment_writer_top verification clean");
		else
			$display("temperature_to_seven_segment_writer_top verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("temperature_to_seven_segment_writer_top verification failed");
		$finish;
	end

endmodule
